// File: rtl/tmwf_pkg.sv
// ----------------------------------------------------------------------------
// tmwf_pkg
// Shared constants and types for the trimmed-mean window filter.
// ----------------------------------------------------------------------------
package tmwf_pkg;

	localparam int WIN_DEPTH   = 10;
	localparam int TRIM_LO     = 3;
	localparam int TRIM_HI     = 7;
	localparam int GAIN_SHIFT  = 8;
	localparam int GAIN_W      = 16;
	localparam int BOUND_W     = 17;
	localparam int FILT_W      = 18;
	localparam int CFG_DATA_W  = 17;
	localparam int CFG_IDX_W   = 2;
	localparam int PASS_W      = $clog2(WIN_DEPTH);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_POS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_NEG = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND    = 2'd2;

	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd256;
	localparam logic [BOUND_W-1:0] BOUND_RESET = 17'd131071;

	typedef struct packed {
		logic [GAIN_W-1:0]  gain_pos;
		logic [GAIN_W-1:0]  gain_neg;
		logic [BOUND_W-1:0] bound;
	} cfg_t;

endpackage

// File: rtl/tmwf_front.sv
// ----------------------------------------------------------------------------
// tmwf_front
// Accepts samples, keeps the age-ordered window and hands a snapshot of the
// updated window to the work queue.
// ----------------------------------------------------------------------------
module tmwf_front #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         in_valid,
	output logic                                         in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]               sample,
	input  logic                                         q_full,
	output logic                                         push,
	output logic [tmwf_pkg::WIN_DEPTH*SAMPLE_WIDTH-1:0]  push_data
);

	logic signed [SAMPLE_WIDTH-1:0] win_q [tmwf_pkg::WIN_DEPTH];
	logic signed [SAMPLE_WIDTH-1:0] win_nxt [tmwf_pkg::WIN_DEPTH];

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		win_nxt[0] = sample;
		for (int k = 1; k < tmwf_pkg::WIN_DEPTH; k++) begin
			win_nxt[k] = win_q[k-1];
		end
		for (int k = 0; k < tmwf_pkg::WIN_DEPTH; k++) begin
			push_data[k*SAMPLE_WIDTH +: SAMPLE_WIDTH] = win_nxt[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < tmwf_pkg::WIN_DEPTH; k++) begin
				win_q[k] <= '0;
			end
		end else if (push) begin
			win_q <= win_nxt;
		end
	end

endmodule

// File: rtl/tmwf_queue.sv
// ----------------------------------------------------------------------------
// tmwf_queue
// Two-entry queue of window snapshots between the front and the back.
// ----------------------------------------------------------------------------
module tmwf_queue #(
	parameter int DATA_W = 160
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic              full,
	output logic              empty,
	output logic [DATA_W-1:0] head
);

	logic [DATA_W-1:0]               mem_q [tmwf_pkg::QUEUE_DEPTH];
	logic [tmwf_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [tmwf_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [tmwf_pkg::QCNT_W-1:0]     cnt_q;

	assign full  = (cnt_q == tmwf_pkg::QCNT_W'(tmwf_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/tmwf_back.sv
// ----------------------------------------------------------------------------
// tmwf_back
// Sorts one window snapshot by odd-even transposition, sums the middle four,
// applies the sign-dependent gain, saturates and holds the result word.
// ----------------------------------------------------------------------------
module tmwf_back #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  tmwf_pkg::cfg_t                               cfg,
	input  logic                                         q_empty,
	input  logic [tmwf_pkg::WIN_DEPTH*SAMPLE_WIDTH-1:0]  q_head,
	output logic                                         pop,
	output logic                                         out_valid,
	input  logic                                         out_stall,
	output logic signed [tmwf_pkg::FILT_W-1:0]           filtered
);

	localparam int SUM_W  = SAMPLE_WIDTH + 2;
	localparam int PROD_W = SUM_W + tmwf_pkg::GAIN_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SORT,
		ST_SUM,
		ST_MUL,
		ST_DONE
	} state_t;

	state_t                              state_q;
	logic [tmwf_pkg::PASS_W-1:0]         pass_q;
	logic signed [SAMPLE_WIDTH-1:0]      vals_q [tmwf_pkg::WIN_DEPTH];
	logic signed [SAMPLE_WIDTH-1:0]      vals_nxt [tmwf_pkg::WIN_DEPTH];
	logic signed [SUM_W-1:0]             sum_q;
	logic signed [SUM_W-1:0]             sum_nxt;
	logic signed [PROD_W-1:0]            prod_q;
	logic signed [PROD_W-1:0]            gain_ext;
	logic signed [PROD_W-1:0]            shifted;
	logic signed [PROD_W-1:0]            bound_ext;
	logic signed [PROD_W-1:0]            clamped;
	logic                                out_valid_q;
	logic signed [tmwf_pkg::FILT_W-1:0]  filtered_q;
	logic                                out_free;

	assign pop       = (state_q == ST_IDLE) && !q_empty;
	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;
	assign out_free  = !out_valid_q || !out_stall;

	// One transposition pass: even passes pair (0,1),(2,3)..., odd passes
	// pair (1,2),(3,4)...; ten passes fully sort ten entries.
	always_comb begin
		vals_nxt = vals_q;
		for (int k = 0; k < tmwf_pkg::WIN_DEPTH - 1; k++) begin
			if ((k[0] == pass_q[0]) && (vals_q[k] > vals_q[k+1])) begin
				vals_nxt[k]   = vals_q[k+1];
				vals_nxt[k+1] = vals_q[k];
			end
		end
	end

	always_comb begin
		sum_nxt = '0;
		for (int k = tmwf_pkg::TRIM_LO; k < tmwf_pkg::TRIM_HI; k++) begin
			sum_nxt = sum_nxt + SUM_W'(vals_q[k]);
		end
	end

	always_comb begin
		if (sum_q < 0) begin
			gain_ext = PROD_W'($signed({1'b0, cfg.gain_neg}));
		end else begin
			gain_ext = PROD_W'($signed({1'b0, cfg.gain_pos}));
		end
		// Arithmetic shift of the signed product rounds toward minus infinity.
		shifted   = prod_q >>> tmwf_pkg::GAIN_SHIFT;
		bound_ext = PROD_W'($signed({1'b0, cfg.bound}));
		if (shifted > bound_ext) begin
			clamped = bound_ext;
		end else if (shifted < -bound_ext) begin
			clamped = -bound_ext;
		end else begin
			clamped = shifted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < tmwf_pkg::WIN_DEPTH; k++) begin
				vals_q[k] <= '0;
			end
			sum_q       <= '0;
			prod_q      <= '0;
			filtered_q  <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						for (int k = 0; k < tmwf_pkg::WIN_DEPTH; k++) begin
							vals_q[k] <= q_head[k*SAMPLE_WIDTH +: SAMPLE_WIDTH];
						end
						pass_q  <= '0;
						state_q <= ST_SORT;
					end
				end
				ST_SORT: begin
					vals_q <= vals_nxt;
					if (pass_q == tmwf_pkg::PASS_W'(tmwf_pkg::WIN_DEPTH - 1)) begin
						state_q <= ST_SUM;
					end else begin
						pass_q <= pass_q + 1'b1;
					end
				end
				ST_SUM: begin
					sum_q   <= sum_nxt;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q  <= PROD_W'(sum_q) * gain_ext;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// A taken word is replaced here; a word still held stays until taken.
					if (out_free) begin
						filtered_q  <= tmwf_pkg::FILT_W'(clamped);
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/trimmed_mean_window_filter_top.sv
// ----------------------------------------------------------------------------
// trimmed_mean_window_filter_top
// The back handles one word at a time, through the ten-pass sort plus its
// load, sum, multiply and output steps; the front takes up to two more
// words into the queue while the back works.
// Reset: the window clears to zero, gains to 1.0 and the bound to 131071.
// ----------------------------------------------------------------------------
module trimmed_mean_window_filter_top #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]          sample,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [tmwf_pkg::FILT_W-1:0]      filtered,
	input  logic                                    wr_en,
	input  logic [tmwf_pkg::CFG_IDX_W-1:0]          wr_index,
	input  logic [tmwf_pkg::CFG_DATA_W-1:0]         wr_data
);

	localparam int SNAP_W = tmwf_pkg::WIN_DEPTH * SAMPLE_WIDTH;

	tmwf_pkg::cfg_t    cfg_q;
	logic              push;
	logic [SNAP_W-1:0] push_data;
	logic              q_full;
	logic              q_empty;
	logic              pop;
	logic [SNAP_W-1:0] q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_pos <= tmwf_pkg::GAIN_RESET;
			cfg_q.gain_neg <= tmwf_pkg::GAIN_RESET;
			cfg_q.bound    <= tmwf_pkg::BOUND_RESET;
		end else if (wr_en) begin
			case (wr_index)
				tmwf_pkg::REG_GAIN_POS: cfg_q.gain_pos <= wr_data[tmwf_pkg::GAIN_W-1:0];
				tmwf_pkg::REG_GAIN_NEG: cfg_q.gain_neg <= wr_data[tmwf_pkg::GAIN_W-1:0];
				tmwf_pkg::REG_BOUND:    cfg_q.bound    <= wr_data[tmwf_pkg::BOUND_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tmwf_front #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sample   (sample),
		.q_full   (q_full),
		.push     (push),
		.push_data(push_data)
	);

	tmwf_queue #(
		.DATA_W(SNAP_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (q_head)
	);

	tmwf_back #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filtered (filtered)
	);

endmodule

// File: rtl/tmwf_checker.sv
// ----------------------------------------------------------------------------
// tmwf_checker
// Port-level checks for the trimmed-mean window filter, bound to the top.
// ----------------------------------------------------------------------------
module tmwf_checker #(
	parameter int SAMPLE_WIDTH = 16
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic signed [SAMPLE_WIDTH-1:0]      sample,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [tmwf_pkg::FILT_W-1:0]  filtered
);

	logic       in_acc;
	logic       out_acc;
	logic [2:0] pending_q;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// Words accepted whose results have not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(filtered))
		else $error("filtered word changed while stalled");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(sample))
		else $error("sample word changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result offered with no word outstanding");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd4)
		else $error("more words in flight than the filter can hold");

	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && pending_q == 3'd0 && !out_valid |=> !out_valid)
		else $error("result appeared the cycle after its sample");

endmodule

bind trimmed_mean_window_filter_top tmwf_checker #(
	.SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_tmwf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.sample   (sample),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.filtered (filtered)
);
